// File: hw/rtl/binary_erosion_3x3_assert.svh
// Assertion macros used by the binary erosion back end.
`ifndef BINARY_EROSION_3X3_ASSERT_SVH
`define BINARY_EROSION_3X3_ASSERT_SVH

// Property checked on every rising clock edge outside reset.
`define BERO3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never hold on a rising clock edge outside reset.
`define BERO3_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: hw/rtl/bero3_pkg.sv
// Types and constants shared by the binary erosion blocks.
`default_nettype none

package bero3_pkg;

  localparam int unsigned MaxWidth = 1024;
  localparam int unsigned AddrW    = $clog2(MaxWidth);
  localparam int unsigned PixW     = 8;
  localparam int unsigned WidthW   = 11;
  localparam int unsigned HeightW  = 12;
  localparam int unsigned CfgW     = 12;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned ColCmpW  = ((WidthW > AddrW + 1) ? WidthW : AddrW + 1) + 1;
  localparam int unsigned RowCmpW  = HeightW + 1;
  localparam int unsigned WinW     = 18;

  localparam logic [CfgIdxW-1:0] RegFrameWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegFrameHeight = 1'b1;

  localparam logic [WidthW-1:0]  WidthReset  = 11'd1024;
  localparam logic [HeightW-1:0] HeightReset = 12'd720;

  localparam logic [PixW-1:0] PixZero = 8'h00;
  localparam logic [PixW-1:0] PixFull = 8'hFF;

  localparam int unsigned FlagZeroBit = 0;
  localparam int unsigned FlagFullBit = 1;

  typedef logic [1:0] flags_t;

  typedef struct packed {
    flags_t            flags;
    logic [AddrW-1:0]  addr;
    logic              emit;
    logic              last;
  } cmd_t;

  typedef struct packed {
    logic zero;
    logic last;
  } res_t;

endpackage

`default_nettype wire

// File: hw/rtl/bero3_front.sv
// Front end: configuration, raster counters and classification of each pixel.
`default_nettype none

module bero3_front import bero3_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgW-1:0]     cfg_data_i,
  input  wire logic                accept_i,
  input  wire logic [PixW-1:0]     in_pixel_i,
  output cmd_t                     cmd_o
);

  logic [WidthW-1:0]  width_q;
  logic [HeightW-1:0] height_q;
  logic [AddrW-1:0]   col_q, col_d;
  logic [HeightW-1:0] row_q, row_d;

  logic [ColCmpW-1:0] w_eff, col_ext, col_inc;
  logic [RowCmpW-1:0] h_eff, row_ext, row_inc;
  flags_t             flags;

  always_comb begin
    w_eff = ColCmpW'(width_q);
    if (width_q == '0) begin
      w_eff = ColCmpW'(1);
    end else if (ColCmpW'(width_q) > ColCmpW'(MaxWidth)) begin
      w_eff = ColCmpW'(MaxWidth);
    end
    h_eff   = (height_q == '0) ? RowCmpW'(1) : RowCmpW'(height_q);
    col_ext = ColCmpW'(col_q);
    col_inc = col_ext + ColCmpW'(1);
    row_ext = RowCmpW'(row_q);
    row_inc = row_ext + RowCmpW'(1);

    flags = '0;
    if (in_pixel_i == PixZero) begin
      flags[FlagZeroBit] = 1'b1;
    end else if (in_pixel_i == PixFull) begin
      flags[FlagFullBit] = 1'b1;
    end

    cmd_o.flags = flags;
    cmd_o.addr  = col_q;
    cmd_o.emit  = (row_ext >= RowCmpW'(2)) && (col_ext >= ColCmpW'(2)) &&
                  (row_ext < h_eff) && (col_ext < w_eff);
    cmd_o.last  = (row_inc == h_eff) && (col_inc == w_eff);

    if (col_inc >= w_eff) begin
      col_d = '0;
      row_d = (row_inc >= h_eff) ? '0 : row_inc[HeightW-1:0];
    end else begin
      col_d = col_inc[AddrW-1:0];
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          RegFrameWidth:  width_q  <= cfg_data_i[WidthW-1:0];
          RegFrameHeight: height_q <= cfg_data_i[HeightW-1:0];
          default: ;
        endcase
      end
      if (accept_i) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/bero3_cmdq.sv
// Two-entry queue of classified pixels between the front and back ends.
`default_nettype none

module bero3_cmdq import bero3_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire cmd_t  data_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output cmd_t       data_o,
  output logic       empty_o
);

  cmd_t       entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/bero3_back.sv
// Back end: line memory, 3x3 window, erosion decision and result buffer.
`default_nettype none

`include "binary_erosion_3x3_assert.svh"

module bero3_back import bero3_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cmd_valid_i,
  input  wire cmd_t             cmd_i,
  output logic                  cmd_pop_o,
  output logic                  empty_o,
  input  wire logic             pop_i,
  output logic [PixW-1:0]       out_pixel_o,
  output logic                  last_o
);

  // Each line entry holds the older row's flags in the low half and the newer row's above.
  logic [3:0]       line_mem [MaxWidth];
  logic [3:0]       rd_q;
  logic [3:0]       byp_q;
  logic             byp_hit_q;
  cmd_t             b1_q;
  logic             b1_valid_q;
  logic [WinW-1:0]  window_q;

  res_t             ob_q [2];
  logic             ob_wr_q, ob_rd_q;
  logic [1:0]       ob_cnt_q;

  logic             adv;
  logic [3:0]       line;
  logic [5:0]       col_flags;
  logic [3:0]       wr_data;
  logic [WinW-1:0]  win_next;
  logic             any_full;
  logic             res_zero;
  logic             ob_push, ob_pop;

  assign adv       = (ob_cnt_q != 2'd2);
  assign cmd_pop_o = adv && cmd_valid_i;
  assign ob_push   = adv && b1_valid_q && b1_q.emit;
  assign ob_pop    = pop_i && (ob_cnt_q != 2'd0);
  assign empty_o   = (ob_cnt_q == 2'd0);
  assign out_pixel_o = ob_q[ob_rd_q].zero ? PixZero : PixFull;
  assign last_o      = ob_q[ob_rd_q].last;

  always_comb begin
    line      = byp_hit_q ? byp_q : rd_q;
    col_flags = {b1_q.flags, line[3:2], line[1:0]};
    wr_data   = {b1_q.flags, line[3:2]};
    win_next  = {col_flags, window_q[WinW-1:6]};
    any_full  = 1'b0;
    for (int k = 0; k < 3; k++) begin
      for (int t = 0; t < 3; t++) begin
        if (!(k == 1 && t == 1)) begin
          any_full = any_full | win_next[6*k + 2*t + FlagFullBit];
        end
      end
    end
    res_zero = win_next[8 + FlagZeroBit] && !any_full;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q <= 1'b0;
      byp_hit_q  <= 1'b0;
      window_q   <= '0;
      ob_wr_q    <= 1'b0;
      ob_rd_q    <= 1'b0;
      ob_cnt_q   <= '0;
    end else begin
      if (adv) begin
        b1_valid_q <= cmd_valid_i;
        byp_hit_q  <= cmd_valid_i && b1_valid_q && (cmd_i.addr == b1_q.addr);
        if (b1_valid_q) begin
          window_q <= win_next;
        end
      end
      if (ob_push) begin
        ob_wr_q <= ~ob_wr_q;
      end
      if (ob_pop) begin
        ob_rd_q <= ~ob_rd_q;
      end
      if (ob_push && !ob_pop) begin
        ob_cnt_q <= ob_cnt_q + 2'd1;
      end else if (ob_pop && !ob_push) begin
        ob_cnt_q <= ob_cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && b1_valid_q) begin
      line_mem[b1_q.addr] <= wr_data;
    end
    if (cmd_pop_o) begin
      rd_q  <= line_mem[cmd_i.addr];
      b1_q  <= cmd_i;
      byp_q <= wr_data;
    end
    if (ob_push) begin
      ob_q[ob_wr_q] <= '{zero: res_zero, last: b1_q.last};
    end
  end

  `BERO3_ASSERT_NEVER(a_ob_overflow, ob_cnt_q > 2'd2, "result buffer count out of range")
  `BERO3_ASSERT(a_bypass_valid, byp_hit_q |-> b1_valid_q, "bypass flagged without a pixel in flight")
  `BERO3_ASSERT(a_ob_fill, (ob_push && !ob_pop) |=> (ob_cnt_q == $past(ob_cnt_q) + 2'd1), "result beat lost")
  `BERO3_ASSERT(a_stall_hold, (!adv && b1_valid_q) |=> (b1_valid_q && $stable(window_q)), "window moved while stalled")

endmodule

`default_nettype wire

// File: hw/rtl/binary_erosion_3x3.sv
// Top level of the streaming 3x3 binary erosion block.
//
//   Channel   Direction  Handshake            Payload
//   input     in         push / full          in_pixel_i
//   result    out        pop / empty          out_pixel_o, last_o
//   config    in         cfg_we_i             cfg_index_i, cfg_data_i
//
// One pixel beat is taken every cycle while the input queue is not full.
// The line memory read is registered as a pixel leaves the queue; the window update and
// write-back for that pixel follow once the result buffer is not full.
// A two-entry queue decouples the front end, and a two-entry buffer holds results under stall.
// Reset clears counters and window; the line memory is not cleared and needs no sweep.
`default_nettype none

module binary_erosion_3x3 import bero3_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push,
  output logic                     full,
  input  wire logic [PixW-1:0]     in_pixel_i,
  output logic                     empty,
  input  wire logic                pop,
  output logic [PixW-1:0]          out_pixel_o,
  output logic                     last_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgW-1:0]     cfg_data_i
);

  cmd_t front_cmd, q_cmd;
  logic accept, q_empty, q_pop;

  assign accept = push && !full;

  bero3_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .in_pixel_i  (in_pixel_i),
    .cmd_o       (front_cmd)
  );

  bero3_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (q_pop),
    .data_o  (q_cmd),
    .empty_o (q_empty)
  );

  bero3_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!q_empty),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_pixel_o (out_pixel_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for binary_erosion_3x3: streams frames and checks each result beat.
module testbench;
  import bero3_pkg::*;

  localparam int unsigned DrainCycles = 8;
  localparam int unsigned LongStall   = 300;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned StallWidth  = 96;

  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic            last;
  } erosion_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic [PixW-1:0]    in_pixel_i = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [PixW-1:0]    out_pixel_o;
  logic               last_o;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = RegFrameWidth;
  logic [CfgW-1:0]    cfg_data_i = '0;

  logic [PixW-1:0] pixel_queue[$];
  erosion_t        eroded_queue[$];
  erosion_t        wanted;

  logic [WidthW-1:0]  frame_width_cfg = WidthReset;
  logic [HeightW-1:0] frame_height_cfg = HeightReset;
  flags_t             older_row[MaxWidth];
  flags_t             newer_row[MaxWidth];
  logic [WinW-1:0]    window = '0;
  int unsigned        col_idx = 0;
  int unsigned        row_idx = 0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned full_pct = 10;
  int unsigned other_pct = 10;
  int unsigned stall_requests = 0;
  int unsigned stall_served = 0;
  int unsigned stall_left = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  binary_erosion_3x3 uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_pixel_i  (in_pixel_i),
    .empty       (empty),
    .pop         (pop),
    .out_pixel_o (out_pixel_o),
    .last_o      (last_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned clamp_width(input logic [WidthW-1:0] raw);
    if (raw == '0) return 1;
    if (raw > MaxWidth) return MaxWidth;
    return 32'(raw);
  endfunction

  function automatic int unsigned clamp_height(input logic [HeightW-1:0] raw);
    return (raw == '0) ? 1 : 32'(raw);
  endfunction

  function automatic void erode_pixel(input logic [PixW-1:0] pix);
    int unsigned w, h, c, r, idx, k;
    flags_t      cur;
    logic        any_full;
    erosion_t    res;
    w = clamp_width(frame_width_cfg);
    h = clamp_height(frame_height_cfg);
    c = col_idx;
    r = row_idx;
    idx = (c < MaxWidth) ? c : MaxWidth - 1;
    cur = '0;
    if (pix == PixZero) cur[FlagZeroBit] = 1'b1;
    else if (pix == PixFull) cur[FlagFullBit] = 1'b1;
    window = {cur, newer_row[idx], older_row[idx], window[WinW-1:6]};
    if (c < MaxWidth) begin
      older_row[idx] = newer_row[idx];
      newer_row[idx] = cur;
    end
    if (r >= 2 && c >= 2 && r < h && c < w) begin
      any_full = 1'b0;
      for (k = 0; k < 9; k++) begin
        if (k != 4 && window[2 * k + FlagFullBit]) any_full = 1'b1;
      end
      res.pixel = (window[8 + FlagZeroBit] && !any_full) ? PixZero : PixFull;
      res.last = (r + 1 == h && c + 1 == w);
      eroded_queue.push_back(res);
    end
    if (c + 1 >= w) begin
      col_idx = 0;
      row_idx = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_idx = c + 1;
    end
  endfunction

  function automatic int unsigned pixels_to_frame_end();
    int unsigned c, r, n, w, h;
    w = clamp_width(frame_width_cfg);
    h = clamp_height(frame_height_cfg);
    c = col_idx;
    r = row_idx;
    n = 0;
    do begin
      n++;
      if (c + 1 >= w) begin
        c = 0;
        r = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        c++;
      end
    end while (c != 0 || r != 0);
    return n;
  endfunction

  // Pixel driver.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else if (!push || !full) begin
      if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        push <= 1'b1;
        in_pixel_i <= pixel_queue.pop_front();
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Result receiver, with long hold-offs on request.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (stall_left != 0) begin
      pop <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_served != stall_requests) begin
      pop <= 1'b0;
      stall_left <= LongStall;
      stall_served <= stall_served + 1;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: tracks configuration, predicts on each pixel beat, checks each result beat.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_index_i == RegFrameWidth) frame_width_cfg = cfg_data_i[WidthW-1:0];
        else if (cfg_index_i == RegFrameHeight) frame_height_cfg = cfg_data_i[HeightW-1:0];
      end
      if (push && !full) erode_pixel(in_pixel_i);
      if (pop && !empty) begin
        if (eroded_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: out_pixel %0d last %0b", out_pixel_o, last_o);
        end else begin
          wanted = eroded_queue.pop_front();
          if (out_pixel_o !== wanted.pixel || last_o !== wanted.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected out_pixel %0d last %0b, got out_pixel %0d last %0b",
                       wanted.pixel, wanted.last, out_pixel_o, last_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("binary_erosion_3x3 regression: fail");
      $finish;
    end
  end

  task automatic settle();
    while (pixel_queue.size() != 0 || push || eroded_queue.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] index, input int unsigned value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= CfgW'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_pixels(input int unsigned count);
    int unsigned roll;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < full_pct) pixel_queue.push_back(PixFull);
      else if (roll < full_pct + other_pct) pixel_queue.push_back(PixW'($urandom_range(254, 1)));
      else pixel_queue.push_back(PixZero);
    end
  endtask

  task automatic random_phase(input int unsigned items);
    int unsigned sent, w_raw, h_raw, w, h, n;
    sent = 0;
    while (sent < items) begin
      settle();
      case ($urandom_range(2))
        0: full_pct = 2;
        1: full_pct = 10;
        default: full_pct = 35;
      endcase
      other_pct = $urandom_range(20);
      if (col_idx == 0 && row_idx == 0) begin
        case ($urandom_range(9))
          0: w_raw = $urandom_range(2);
          9: w_raw = $urandom_range(40, 13);
          default: w_raw = $urandom_range(12, 3);
        endcase
        h_raw = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(8, 3);
        write_reg(RegFrameWidth, w_raw);
        write_reg(RegFrameHeight, h_raw);
        w = clamp_width(frame_width_cfg);
        h = clamp_height(frame_height_cfg);
        if ($urandom_range(3) == 0 && w * h > 1) n = $urandom_range(w * h - 1, 1);
        else n = $urandom_range(2, 1) * w * h;
      end else begin
        // Mid-frame: the row may not widen, so no line store entry is read unwritten.
        w_raw = $urandom_range(clamp_width(frame_width_cfg));
        h_raw = $urandom_range(9);
        case ($urandom_range(2))
          0: write_reg(RegFrameWidth, w_raw);
          1: write_reg(RegFrameHeight, h_raw);
          default: begin
            write_reg(RegFrameWidth, w_raw);
            write_reg(RegFrameHeight, h_raw);
          end
        endcase
        n = pixels_to_frame_end();
      end
      send_pixels(n);
      sent += n;
    end
  endtask

  initial begin
    for (int i = 0; i < MaxWidth; i++) begin
      older_row[i] = '0;
      newer_row[i] = '0;
    end
    send_idle_pct = 25;
    recv_idle_pct = 53;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    write_reg(RegFrameWidth, 5);
    write_reg(RegFrameHeight, 3);
    repeat (4) pixel_queue.push_back(PixZero);
    pixel_queue.push_back(PixFull);
    repeat (2) pixel_queue.push_back(PixZero);
    pixel_queue.push_back(8'd128);
    repeat (7) pixel_queue.push_back(PixZero);
    settle();

    write_reg(RegFrameWidth, 0);
    write_reg(RegFrameHeight, 0);
    pixel_queue.push_back(PixFull);
    pixel_queue.push_back(PixZero);
    settle();

    write_reg(RegFrameWidth, 2047);
    write_reg(RegFrameHeight, 4095);
    pixel_queue.push_back(PixFull);
    pixel_queue.push_back(8'd1);
    pixel_queue.push_back(8'd254);
    pixel_queue.push_back(PixZero);
    settle();
    write_reg(RegFrameWidth, 3);
    write_reg(RegFrameHeight, 3);
    full_pct = 15;
    other_pct = 10;
    send_pixels(7);
    settle();

    // One wide frame, with the receiver holding off so the input backs up.
    write_reg(RegFrameWidth, StallWidth);
    write_reg(RegFrameHeight, 3);
    full_pct = 2;
    send_pixels(3 * StallWidth);
    stall_requests++;
    random_phase(300);

    send_idle_pct = 53;
    recv_idle_pct = 25;
    random_phase(300);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(300);

    settle();
    if (mismatches == 0) begin
      $display("binary_erosion_3x3 regression: pass");
    end else begin
      $display("binary_erosion_3x3 regression: fail");
    end
    $finish;
  end

endmodule
